FILE: rtl/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failure");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failure");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/mck_pkg.sv
package mck_pkg;

  localparam int ROUNDS      = 32;
  localparam int ROT         = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] REG_KEY_12   = 3'd0;
  localparam logic [2:0] REG_KEY_34   = 3'd1;
  localparam logic [2:0] REG_KEY_56   = 3'd2;
  localparam logic [2:0] REG_KEY_78   = 3'd3;
  localparam logic [2:0] REG_INIT_CTR = 3'd4;

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
      4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
    '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
      4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
    '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
      4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
    '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
      4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
    '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
      4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
    '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
      4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
    '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
      4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
    '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
      4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
  };

  // Round keys, index 0 is K1.
  typedef logic [7:0][31:0] key_set_t;

  typedef struct packed {
    logic [63:0] ctr;
    logic [63:0] data;
    logic [3:0]  nbytes;
  } job_t;

  function automatic logic [31:0] magma_g(input logic [31:0] half, input logic [31:0] rk);
    logic [31:0] s;
    logic [31:0] t;
    s = half + rk;
    t = '0;
    for (int n = 0; n < 8; n++) begin
      t[4*n +: 4] = SBOX[n][s[4*n +: 4]];
    end
    return {t[31-ROT:0], t[31:32-ROT]};
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] nbytes);
    logic [63:0] m;
    for (int b = 0; b < 8; b++) begin
      m[63-8*b -: 8] = (4'(b) < nbytes) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

FILE: rtl/mck_in_if.sv
interface mck_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_block;
  logic [3:0]  valid_bytes;
  logic        restart;

  modport source(output valid, data_block, valid_bytes, restart, input ready);
  modport sink(input valid, data_block, valid_bytes, restart, output ready);
endinterface

FILE: rtl/mck_out_if.sv
interface mck_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_block;
  logic [3:0]  result_bytes;

  modport source(output valid, result_block, result_bytes, input ready);
  modport sink(input valid, result_block, result_bytes, output ready);
endinterface

FILE: rtl/mck_front.sv
module mck_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [63:0]   init_ctr,
  mck_in_if.sink        src,
  output logic          push_valid,
  input  logic          push_ready,
  output mck_pkg::job_t push_job
);

  logic [63:0] counter;
  logic [63:0] cur_ctr;
  logic [3:0]  nb_sat;

  always_comb begin
    cur_ctr = src.restart ? init_ctr : counter;
    priority if (src.valid_bytes == 4'd0) begin
      nb_sat = 4'd1;
    end else if (src.valid_bytes > 4'd8) begin
      nb_sat = 4'd8;
    end else begin
      nb_sat = src.valid_bytes;
    end
  end

  assign src.ready       = push_ready;
  assign push_valid      = src.valid;
  assign push_job.ctr    = cur_ctr;
  assign push_job.data   = src.data_block;
  assign push_job.nbytes = nb_sat;

  // advance the running counter on every transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (src.valid && push_ready) begin
      counter <= cur_ctr + 64'd1;
    end
  end

endmodule

FILE: rtl/mck_queue.sv
module mck_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  mck_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mck_pkg::job_t pop_job
);

  mck_pkg::job_t               mem [mck_pkg::QUEUE_DEPTH];
  logic [mck_pkg::QPTR_W-1:0]  wr_ptr;
  logic [mck_pkg::QPTR_W-1:0]  rd_ptr;
  logic [mck_pkg::QCNT_W-1:0]  count;
  logic                        push;
  logic                        pop;

  assign push_ready = (count != mck_pkg::QCNT_W'(mck_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mck_pkg::QPTR_W'(mck_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == mck_pkg::QPTR_W'(mck_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/mck_rounds.sv
module mck_rounds (
  input  logic              clk,
  input  logic              rst,
  input  mck_pkg::key_set_t keys,
  input  logic              job_valid,
  output logic              job_ready,
  input  mck_pkg::job_t     job,
  mck_out_if.source         dst
);

  localparam int R = mck_pkg::ROUNDS;

  logic [31:0] in_hi   [R];
  logic [31:0] in_lo   [R];
  logic [63:0] in_data [R];
  logic [3:0]  in_nb   [R];
  logic        in_vld  [R];
  logic [31:0] nh      [R];

  logic [31:0] st_hi   [R];
  logic [31:0] st_lo   [R];
  logic [63:0] st_data [R];
  logic [3:0]  st_nb   [R];
  logic        st_vld  [R];

  logic        adv;

  // whole pipe moves together; it holds only when the output register is stuck
  assign adv       = !dst.valid || dst.ready;
  assign job_ready = adv;

  always_comb begin
    in_hi[0]   = job.ctr[63:32];
    in_lo[0]   = job.ctr[31:0];
    in_data[0] = job.data;
    in_nb[0]   = job.nbytes;
    in_vld[0]  = job_valid;
    for (int r = 1; r < R; r++) begin
      in_hi[r]   = st_hi[r-1];
      in_lo[r]   = st_lo[r-1];
      in_data[r] = st_data[r-1];
      in_nb[r]   = st_nb[r-1];
      in_vld[r]  = st_vld[r-1];
    end
  end

  for (genvar r = 0; r < R; r++) begin : g_round
    // K1..K8 three times, then K8..K1
    localparam int KI = (r < R - 8) ? (r % 8) : (7 - (r % 8));

    assign nh[r] = mck_pkg::magma_g(in_lo[r], keys[KI]) ^ in_hi[r];

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[r] <= 1'b0;
      end else if (adv) begin
        st_vld[r] <= in_vld[r];
      end
    end

    // no swap after the last round
    always_ff @(posedge clk) begin
      if (adv) begin
        st_hi[r]   <= (r == R - 1) ? nh[r] : in_lo[r];
        st_lo[r]   <= (r == R - 1) ? in_lo[r] : nh[r];
        st_data[r] <= in_data[r];
        st_nb[r]   <= in_nb[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (adv) begin
      dst.valid <= st_vld[R-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dst.result_block <= (st_data[R-1] ^ {st_hi[R-1], st_lo[R-1]})
                          & mck_pkg::byte_mask(st_nb[R-1]);
      dst.result_bytes <= st_nb[R-1];
    end
  end

endmodule

FILE: rtl/magma_ctr_keystream_xor.sv
// Magma block cipher in counter mode: XORs the keystream onto up to eight
// data bytes per transfer (first byte in bits 63..56).
// Channels: data_in carries data_block, valid_bytes (1..8, saturated) and
// restart; data_out carries result_block (unused low bytes zeroed) and
// result_bytes. Both use valid/ready; a transfer happens when both are high.
// Configuration: wr_en/wr_index/wr_data write the four key words and the
// initial counter; write only while no block is in flight.
// Throughput: one block per cycle while data_out does not stall. The 32
// rounds are one pipeline stage each. An accepted block passes through the
// input queue, which takes it at the transfer edge, then the 32 round
// stages and one output register.
// A set restart loads the counter from the initial counter before the block;
// the counter then increments modulo 2^64 after every block.
// Reset clears the configuration registers, the counter and all valid flags.
// When data_out stalls the round pipeline holds; the two-entry input queue
// keeps taking blocks until it fills, then data_in.ready drops.
`include "assert_macros.svh"

module magma_ctr_keystream_xor (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data,
  mck_in_if.sink      data_in,
  mck_out_if.source   data_out
);

  logic [63:0]       key_12;
  logic [63:0]       key_34;
  logic [63:0]       key_56;
  logic [63:0]       key_78;
  logic [63:0]       init_ctr;
  mck_pkg::key_set_t keys;

  logic              push_valid;
  logic              push_ready;
  mck_pkg::job_t     push_job;
  logic              q_valid;
  logic              q_ready;
  mck_pkg::job_t     q_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_12   <= '0;
      key_34   <= '0;
      key_56   <= '0;
      key_78   <= '0;
      init_ctr <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        mck_pkg::REG_KEY_12:   key_12   <= wr_data;
        mck_pkg::REG_KEY_34:   key_34   <= wr_data;
        mck_pkg::REG_KEY_56:   key_56   <= wr_data;
        mck_pkg::REG_KEY_78:   key_78   <= wr_data;
        mck_pkg::REG_INIT_CTR: init_ctr <= wr_data;
        default: ;
      endcase
    end
  end

  assign keys[0] = key_12[63:32];
  assign keys[1] = key_12[31:0];
  assign keys[2] = key_34[63:32];
  assign keys[3] = key_34[31:0];
  assign keys[4] = key_56[63:32];
  assign keys[5] = key_56[31:0];
  assign keys[6] = key_78[63:32];
  assign keys[7] = key_78[31:0];

  mck_front u_front (
    .clk        (clk),
    .rst        (rst),
    .init_ctr   (init_ctr),
    .src        (data_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  mck_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  mck_rounds u_rounds (
    .clk       (clk),
    .rst       (rst),
    .keys      (keys),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .dst       (data_out)
  );

  `ASSERT_NEXT(a_accept_fills_queue, clk, rst, data_in.valid && data_in.ready, q_valid)
  `ASSERT_IMPLIES(a_full_not_empty, clk, rst, !data_in.ready, q_valid)
  `ASSERT_IMPLIES(a_pop_only_on_advance, clk, rst, q_valid && q_ready,
                  !data_out.valid || data_out.ready)

endmodule
